>>> rtl/core/tra_pkg.sv
// Shared constants, types and window helpers for the tick rate window averager.
package tra_pkg;

	// Window lengths in samples.
	localparam int unsigned SHORT_WINDOW     = 5;
	localparam int unsigned MINUTE_WINDOW    = 60;
	localparam int unsigned HALF_HOUR_WINDOW = 1800;
	localparam int unsigned HOUR_WINDOW      = 3600;

	localparam int unsigned NUM_WIN = 4;
	localparam int unsigned WIN_W   = 2;

	localparam int unsigned MAX_WIN_A = (SHORT_WINDOW > MINUTE_WINDOW) ? SHORT_WINDOW
		: MINUTE_WINDOW;
	localparam int unsigned MAX_WIN_B = (HALF_HOUR_WINDOW > HOUR_WINDOW) ? HALF_HOUR_WINDOW
		: HOUR_WINDOW;
	localparam int unsigned MAX_WIN   = (MAX_WIN_A > MAX_WIN_B) ? MAX_WIN_A : MAX_WIN_B;

	localparam int unsigned CNT_W = $clog2(MAX_WIN + 1);
	localparam int unsigned POS_W = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1;

	localparam int unsigned RING_DEPTH = SHORT_WINDOW + MINUTE_WINDOW + HALF_HOUR_WINDOW
		+ HOUR_WINDOW;
	localparam int unsigned RING_AW    = $clog2(RING_DEPTH);

	// Field and datapath widths.
	localparam int unsigned TS_W      = 32;
	localparam int unsigned TPU_W     = 16;
	localparam int unsigned SAMPLE_W  = 26;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned AVG_W     = 17;
	localparam int unsigned USEC_W    = 20;
	localparam int unsigned SCALE_W   = 7;
	localparam int unsigned PROD_W    = TPU_W + USEC_W;
	localparam int unsigned PRE_SHIFT = SAMPLE_W - FRAC_W;
	localparam int unsigned SUM_W     = SAMPLE_W + CNT_W;
	localparam int unsigned NUM_W     = SUM_W + SCALE_W + 1;
	localparam int unsigned DIV_W     = TS_W;
	localparam int unsigned STEP_W    = $clog2(DIV_W + 1);

	// Configuration port.
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	typedef logic [WIN_W-1:0]       win_idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [POS_W-1:0]       pos_t;
	typedef logic [SUM_W-1:0]       sum_t;
	typedef logic [SAMPLE_W-1:0]    sample_t;
	typedef logic [RING_AW-1:0]     ring_addr_t;
	typedef logic [AVG_W-1:0]       avg_t;
	typedef logic [TPU_W-1:0]       tpu_t;
	typedef logic [DIV_W-1:0]       div_word_t;
	typedef logic [STEP_W-1:0]      div_step_t;
	typedef logic [PADDR_W-3:0]     reg_idx_t;

	localparam win_idx_t WIN_SHORT     = 2'd0;
	localparam win_idx_t WIN_MINUTE    = 2'd1;
	localparam win_idx_t WIN_HALF_HOUR = 2'd2;
	localparam win_idx_t WIN_HOUR      = 2'd3;

	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam reg_idx_t REG_UPDATE_PERIOD = '0;

	localparam tpu_t                TPU_RESET    = 16'd125;
	localparam logic [USEC_W-1:0]   USEC_PER_SEC = 20'd1000000;
	localparam logic [SCALE_W-1:0]  AVG_SCALE    = 7'd100;
	localparam sample_t             SAMPLE_MAX   = {SAMPLE_W{1'b1}};
	localparam avg_t                AVG_MAX      = 17'd102400;

	// Request to the shared divider: remainder seed, dividend bits (MSB first),
	// divisor and number of quotient bits to produce.
	typedef struct packed {
		logic      start;
		div_word_t rem;
		div_word_t bits;
		div_word_t divisor;
		div_step_t steps;
	} div_req_t;

	typedef struct packed {
		logic      done;
		div_word_t quot;
	} div_rsp_t;

	function automatic cnt_t win_size(input win_idx_t w);
		cnt_t s;
		unique case (w)
			WIN_SHORT:     s = CNT_W'(SHORT_WINDOW);
			WIN_MINUTE:    s = CNT_W'(MINUTE_WINDOW);
			WIN_HALF_HOUR: s = CNT_W'(HALF_HOUR_WINDOW);
			WIN_HOUR:      s = CNT_W'(HOUR_WINDOW);
		endcase
		return s;
	endfunction

	// Each ring occupies its own slice of the shared sample memory.
	function automatic ring_addr_t win_base(input win_idx_t w);
		ring_addr_t b;
		unique case (w)
			WIN_SHORT:     b = '0;
			WIN_MINUTE:    b = RING_AW'(SHORT_WINDOW);
			WIN_HALF_HOUR: b = RING_AW'(SHORT_WINDOW + MINUTE_WINDOW);
			WIN_HOUR:      b = RING_AW'(SHORT_WINDOW + MINUTE_WINDOW + HALF_HOUR_WINDOW);
		endcase
		return b;
	endfunction

endpackage

>>> rtl/core/tra_ram.sv
// Simple dual-port synchronous RAM with a registered read.
module tra_ram #(
	parameter int unsigned DEPTH = 4,
	parameter int unsigned WIDTH = 8,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/tra_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module tra_div import tra_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	div_word_t      rem_q;
	div_word_t      bits_q;
	div_word_t      divisor_q;
	div_word_t      quot_q;
	div_step_t      cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [DIV_W:0] trial;
	logic [DIV_W:0] diff;
	logic           fits;

	// The remainder always stays below the divisor, so one extra bit is enough.
	always_comb begin
		trial = {rem_q, bits_q[DIV_W-1]};
		diff  = trial - {1'b0, divisor_q};
		fits  = (trial >= {1'b0, divisor_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			bits_q    <= '0;
			divisor_q <= '0;
			quot_q    <= '0;
			cnt_q     <= '0;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q     <= req.rem;
				bits_q    <= req.bits;
				divisor_q <= req.divisor;
				quot_q    <= '0;
				cnt_q     <= req.steps;
				busy_q    <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
				bits_q <= {bits_q[DIV_W-2:0], 1'b0};
				quot_q <= {quot_q[DIV_W-2:0], fits};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == div_step_t'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

>>> rtl/core/tick_rate_window_averager.sv
// Tick rate window averager: event rate sampling with four sliding-window averages.
//
// Input channel (in_valid/in_ready): func selects a tick (timestamp_us in
// microseconds) or a query. Output channel (out_valid/out_ready): one transfer
// of the four averages, in hundredths per second, for every query.
// A tick that only counts just updates the tick counter. A tick that closes an
// update period runs a multiply, a divide of the scaled tick count by the elapsed
// time (skipped when the rate saturates), and for each window a read, modify and
// write of the shared sample memory. A query runs, for each window, a multiply
// and a divide of the running sum by the fill count, all through one shared
// iterative divider. Empty windows skip the divide.
// Items are worked one at a time; in_ready is high while the block is idle.
// The result sits in an output register, so a stalled receiver does not block
// ticks; only a second query waits until the previous result has been taken.
// Reset clears the counters, fill counts and running sums and restores the
// update period register to 125. The sample memory is not cleared: an entry read
// back is only used once its ring is full. The first tick after reset sets the time reference.
module tick_rate_window_averager import tra_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                func,
	input  logic [TS_W-1:0]     timestamp_us,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [AVG_W-1:0]    avg_short,
	output logic [AVG_W-1:0]    avg_minute,
	output logic [AVG_W-1:0]    avg_half_hour,
	output logic [AVG_W-1:0]    avg_hour
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_SCHK,
		S_SDIV,
		S_PRD,
		S_PWR,
		S_QMUL,
		S_QSTART,
		S_QDIV,
		S_QDONE
	} state_t;

	state_t            state_q;
	tpu_t              tpu_q;
	tpu_t              tick_cnt_q;
	logic [TS_W-1:0]   ref_q;
	logic              have_ref_q;
	logic [TS_W-1:0]   elapsed_q;
	tpu_t              upd_ticks_q;
	logic [PROD_W-1:0] prod_q;
	sample_t           sample_q;
	win_idx_t          w_q;
	pos_t              pos_q [NUM_WIN];
	cnt_t              fill_q [NUM_WIN];
	sum_t              sum_q [NUM_WIN];
	logic [NUM_W-1:0]  num_q;
	avg_t              avg_tmp_q [NUM_WIN];
	logic              out_valid_q;
	avg_t              avg_short_q;
	avg_t              avg_minute_q;
	avg_t              avg_half_hour_q;
	avg_t              avg_hour_q;

	logic              in_accept;
	logic              cfg_write;
	tpu_t              tpu_eff;
	tpu_t              tick_next;
	logic              sat;
	ring_addr_t        ring_addr;
	sample_t           ring_rdata;
	logic              ring_re;
	logic              ring_we;
	logic              cur_full;
	sum_t              sum_next;
	pos_t              pos_next;
	logic [NUM_W-1:0]  avg_num;
	logic              last_win;
	logic              out_free;
	logic              out_load;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	// Configuration register.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite
		&& (paddr[PADDR_W-1:2] == REG_UPDATE_PERIOD);
	assign prdata    = (paddr[PADDR_W-1:2] == REG_UPDATE_PERIOD)
		? {{(PDATA_W-TPU_W){1'b0}}, tpu_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= TPU_RESET;
		end else if (cfg_write) begin
			tpu_q <= pwdata[TPU_W-1:0];
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign in_accept = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = (state_q == S_QDONE) && out_free;

	always_comb begin
		tpu_eff   = (tpu_q == '0) ? tpu_t'(1) : tpu_q;
		tick_next = tick_cnt_q + 1'b1;
		// The rate saturates when the integer part of the quotient overflows.
		sat       = {{(DIV_W-(PROD_W-PRE_SHIFT)){1'b0}}, prod_q[PROD_W-1:PRE_SHIFT]}
			>= elapsed_q;
		ring_addr = win_base(w_q) + RING_AW'(pos_q[w_q]);
		cur_full  = (fill_q[w_q] == win_size(w_q));
		sum_next  = cur_full ? (sum_q[w_q] - SUM_W'(ring_rdata) + SUM_W'(sample_q))
			: (sum_q[w_q] + SUM_W'(sample_q));
		pos_next  = (pos_q[w_q] == POS_W'(win_size(w_q) - 1'b1)) ? '0
			: pos_q[w_q] + 1'b1;
		avg_num   = (NUM_W'(sum_q[w_q]) * AVG_SCALE)
			+ (NUM_W'(fill_q[w_q]) << (FRAC_W - 1));
		last_win  = (w_q == win_idx_t'(NUM_WIN - 1));
		ring_re   = (state_q == S_PRD);
		ring_we   = (state_q == S_PWR);
	end

	always_comb begin
		div_req = '0;
		if ((state_q == S_SCHK) && !sat) begin
			div_req.start   = 1'b1;
			div_req.rem     = DIV_W'(prod_q[PROD_W-1:PRE_SHIFT]);
			div_req.bits    = {prod_q[PRE_SHIFT-1:0], {(DIV_W-PRE_SHIFT){1'b0}}};
			div_req.divisor = elapsed_q;
			div_req.steps   = STEP_W'(SAMPLE_W);
		end else if ((state_q == S_QSTART) && (fill_q[w_q] != '0)) begin
			// The average fits in AVG_W bits, so the high part seeds the remainder.
			div_req.start   = 1'b1;
			div_req.rem     = DIV_W'(num_q[NUM_W-1:FRAC_W+AVG_W]);
			div_req.bits    = {num_q[FRAC_W+AVG_W-1:FRAC_W], {(DIV_W-AVG_W){1'b0}}};
			div_req.divisor = DIV_W'(fill_q[w_q]);
			div_req.steps   = STEP_W'(AVG_W);
		end
	end

	tra_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tra_ram #(
		.DEPTH (RING_DEPTH),
		.WIDTH (SAMPLE_W)
	) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_addr),
		.wdata (sample_q),
		.re    (ring_re),
		.raddr (ring_addr),
		.rdata (ring_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			tick_cnt_q      <= '0;
			ref_q           <= '0;
			have_ref_q      <= 1'b0;
			elapsed_q       <= '0;
			upd_ticks_q     <= '0;
			prod_q          <= '0;
			sample_q        <= '0;
			w_q             <= '0;
			num_q           <= '0;
			out_valid_q     <= 1'b0;
			avg_short_q     <= '0;
			avg_minute_q    <= '0;
			avg_half_hour_q <= '0;
			avg_hour_q      <= '0;
			for (int i = 0; i < NUM_WIN; i++) begin
				pos_q[i]     <= '0;
				fill_q[i]    <= '0;
				sum_q[i]     <= '0;
				avg_tmp_q[i] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						priority if (func == FUNC_QUERY) begin
							w_q     <= '0;
							state_q <= S_QMUL;
						end else if (!have_ref_q) begin
							have_ref_q <= 1'b1;
							ref_q      <= timestamp_us;
						end else if (tick_next < tpu_eff) begin
							tick_cnt_q <= tick_next;
						end else begin
							tick_cnt_q  <= '0;
							elapsed_q   <= timestamp_us - ref_q;
							ref_q       <= timestamp_us;
							upd_ticks_q <= tpu_eff;
							state_q     <= S_MUL;
						end
					end
				end
				S_MUL: begin
					prod_q  <= upd_ticks_q * USEC_PER_SEC;
					state_q <= S_SCHK;
				end
				S_SCHK: begin
					if (sat) begin
						sample_q <= SAMPLE_MAX;
						w_q      <= '0;
						state_q  <= S_PRD;
					end else begin
						state_q <= S_SDIV;
					end
				end
				S_SDIV: begin
					if (div_rsp.done) begin
						sample_q <= div_rsp.quot[SAMPLE_W-1:0];
						w_q      <= '0;
						state_q  <= S_PRD;
					end
				end
				S_PRD: begin
					state_q <= S_PWR;
				end
				S_PWR: begin
					// The old entry is only subtracted once the ring has wrapped.
					sum_q[w_q] <= sum_next;
					pos_q[w_q] <= pos_next;
					if (!cur_full) begin
						fill_q[w_q] <= fill_q[w_q] + 1'b1;
					end
					if (last_win) begin
						state_q <= S_IDLE;
					end else begin
						w_q     <= w_q + 1'b1;
						state_q <= S_PRD;
					end
				end
				S_QMUL: begin
					num_q   <= avg_num;
					state_q <= S_QSTART;
				end
				S_QSTART: begin
					if (fill_q[w_q] == '0) begin
						avg_tmp_q[w_q] <= '0;
						if (last_win) begin
							state_q <= S_QDONE;
						end else begin
							w_q     <= w_q + 1'b1;
							state_q <= S_QMUL;
						end
					end else begin
						state_q <= S_QDIV;
					end
				end
				S_QDIV: begin
					if (div_rsp.done) begin
						avg_tmp_q[w_q] <= div_rsp.quot[AVG_W-1:0];
						if (last_win) begin
							state_q <= S_QDONE;
						end else begin
							w_q     <= w_q + 1'b1;
							state_q <= S_QMUL;
						end
					end
				end
				S_QDONE: begin
					if (out_free) begin
						avg_short_q     <= avg_tmp_q[WIN_SHORT];
						avg_minute_q    <= avg_tmp_q[WIN_MINUTE];
						avg_half_hour_q <= avg_tmp_q[WIN_HALF_HOUR];
						avg_hour_q      <= avg_tmp_q[WIN_HOUR];
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign avg_short     = avg_short_q;
	assign avg_minute    = avg_minute_q;
	assign avg_half_hour = avg_half_hour_q;
	assign avg_hour      = avg_hour_q;

endmodule

>>> rtl/core/tra_checker.sv
// Port-level checker for the tick rate window averager and its bind.
module tra_checker import tra_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             func,
	input logic             out_valid,
	input logic             out_ready,
	input logic [AVG_W-1:0] avg_short,
	input logic [AVG_W-1:0] avg_minute,
	input logic [AVG_W-1:0] avg_half_hour,
	input logic [AVG_W-1:0] avg_hour
);

	// A query moves the block out of idle, so the input side closes right after it.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == FUNC_QUERY) |=> !in_ready)
		else $error("input still ready after a query transfer");

	// A tick never produces a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == FUNC_TICK) && !out_valid |=> !out_valid)
		else $error("result appeared after a tick transfer");

	// Averages of saturated Q10.16 samples cannot exceed the top rate.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (avg_short <= AVG_MAX) && (avg_minute <= AVG_MAX)
			&& (avg_half_hour <= AVG_MAX) && (avg_hour <= AVG_MAX))
		else $error("average above the representable rate");

	// A stalled result holds until its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(avg_short) && $stable(avg_minute)
			&& $stable(avg_half_hour) && $stable(avg_hour))
		else $error("stalled result changed or dropped");

endmodule

bind tick_rate_window_averager tra_checker u_tra_checker (.*);

>>> tb/sv/tra_window_checker.sv
`timescale 1ns / 100ps
// Watches the averager's ports, predicts the four window averages and flags every mismatch.
module tra_window_checker import tra_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic [PDATA_W-1:0] prdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               func,
	input  logic [TS_W-1:0]    timestamp_us,
	input  logic               out_valid,
	input  logic               out_ready,
	input  avg_t               avg_short,
	input  avg_t               avg_minute,
	input  avg_t               avg_half_hour,
	input  avg_t               avg_hour,
	output int                 mismatches,
	output int                 outstanding
);

	typedef struct packed {
		avg_t short_avg;
		avg_t minute_avg;
		avg_t half_hour_avg;
		avg_t hour_avg;
	} averages_t;

	averages_t expected_averages [$];

	tpu_t            tpu_setting;
	tpu_t            tick_tally;
	logic [TS_W-1:0] ref_stamp;
	logic            ref_valid;
	sample_t         ring_store [NUM_WIN][MAX_WIN];
	int unsigned     ring_head [NUM_WIN];
	int unsigned     ring_fill [NUM_WIN];
	logic [63:0]     ring_total [NUM_WIN];

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	task automatic report(input string msg);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input avg_t got, input avg_t want);
		if (got !== want)
			report($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	function automatic int unsigned window_length(input int w);
		case (win_idx_t'(w))
			WIN_SHORT:     return SHORT_WINDOW;
			WIN_MINUTE:    return MINUTE_WINDOW;
			WIN_HALF_HOUR: return HALF_HOUR_WINDOW;
			default:       return HOUR_WINDOW;
		endcase
	endfunction

	// Rate in Q10.16 samples per second, saturating on zero or very short elapsed time.
	function automatic sample_t rate_sample(input tpu_t ticks, input logic [TS_W-1:0] elapsed);
		logic [63:0] q;
		if (elapsed == '0)
			return SAMPLE_MAX;
		q = (64'(ticks) * 64'(USEC_PER_SEC) * (64'd1 << FRAC_W)) / 64'(elapsed);
		return (q > 64'(SAMPLE_MAX)) ? SAMPLE_MAX : sample_t'(q);
	endfunction

	task automatic record_sample(input sample_t sample);
		int unsigned len;
		int unsigned pos;
		for (int w = 0; w < NUM_WIN; w++) begin
			len = window_length(w);
			pos = (ring_head[w] >= len) ? 0 : ring_head[w];
			// A full ring drops its oldest entry from the running sum.
			if (ring_fill[w] >= len)
				ring_total[w] -= 64'(ring_store[w][pos]);
			else
				ring_fill[w]++;
			ring_store[w][pos] = sample;
			ring_total[w] += 64'(sample);
			pos++;
			ring_head[w] = (pos >= len) ? 0 : pos;
		end
	endtask

	task automatic absorb_tick(input logic [TS_W-1:0] stamp);
		tpu_t period;
		tpu_t count;
		logic [TS_W-1:0] elapsed;
		period = (tpu_setting == '0) ? tpu_t'(1) : tpu_setting;
		count = tick_tally + tpu_t'(1);
		if (!ref_valid) begin
			ref_valid = 1'b1;
			ref_stamp = stamp;
		end else if (count < period) begin
			tick_tally = count;
		end else begin
			tick_tally = '0;
			elapsed = stamp - ref_stamp;
			ref_stamp = stamp;
			record_sample(rate_sample(period, elapsed));
		end
	endtask

	function automatic avg_t window_mean(input int w);
		logic [63:0] fill;
		logic [63:0] num;
		if (ring_fill[w] == 0)
			return '0;
		fill = 64'(ring_fill[w]);
		num = ring_total[w] * 64'(AVG_SCALE) + fill * 64'd32768;
		return avg_t'(num / (fill << FRAC_W));
	endfunction

	function automatic averages_t current_averages();
		averages_t a;
		a.short_avg     = window_mean(WIN_SHORT);
		a.minute_avg    = window_mean(WIN_MINUTE);
		a.half_hour_avg = window_mean(WIN_HALF_HOUR);
		a.hour_avg      = window_mean(WIN_HOUR);
		return a;
	endfunction

	always @(posedge clk) begin : watch
		averages_t want;
		if (!arst_n) begin
			tpu_setting = TPU_RESET;
			tick_tally = '0;
			ref_stamp = '0;
			ref_valid = 1'b0;
			for (int w = 0; w < NUM_WIN; w++) begin
				ring_head[w] = 0;
				ring_fill[w] = 0;
				ring_total[w] = '0;
			end
			expected_averages.delete();
		end else begin
			if (psel && penable && pready && reg_idx_t'(paddr >> 2) == REG_UPDATE_PERIOD) begin
				if (pwrite)
					tpu_setting = tpu_t'(pwdata);
				else if (prdata !== PDATA_W'(tpu_setting))
					report($sformatf("update period read %0d, expected %0d",
						prdata, tpu_setting));
			end
			// Results are matched before inputs: a result can never belong to a
			// query that transfers at the same edge.
			if (out_valid && out_ready) begin
				if (expected_averages.size() == 0) begin
					report($sformatf("result with no query waiting (avg_short %0d)",
						avg_short));
				end else begin
					want = expected_averages.pop_front();
					check_field("avg_short", avg_short, want.short_avg);
					check_field("avg_minute", avg_minute, want.minute_avg);
					check_field("avg_half_hour", avg_half_hour, want.half_hour_avg);
					check_field("avg_hour", avg_hour, want.hour_avg);
				end
			end
			if (in_valid && in_ready) begin
				if (func == FUNC_QUERY)
					expected_averages.push_back(current_averages());
				else
					absorb_tick(timestamp_us);
			end
		end
		outstanding = expected_averages.size();
	end

endmodule

>>> tb/sv/tick_rate_window_averager_tb.sv
`timescale 1ns / 100ps
// Testbench top for the tick rate window averager: clock, reset, stimulus and verdict.
module tick_rate_window_averager_tb;
	import tra_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int LONG_HOLD     = 3000;
	localparam int SETTLE_CYCLES = 150;
	localparam int NUM_PHASES    = 8;
	localparam logic [PADDR_W-1:0] TPU_ADDR = PADDR_W'({REG_UPDATE_PERIOD, 2'b00});

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic               func;
	logic [TS_W-1:0]    timestamp_us;
	logic               out_valid;
	logic               out_ready;
	avg_t               avg_short;
	avg_t               avg_minute;
	avg_t               avg_half_hour;
	avg_t               avg_hour;
	int                 failures;
	int                 outstanding;

	logic [TS_W-1:0] clock_us;
	logic            calm = 1'b0;
	logic            hold_output = 1'b0;
	int              cycle_count;

	tpu_t phase_tpu [NUM_PHASES] = '{16'd1, 16'd3, 16'd0, 16'hFFFF, 16'd2, 16'd1, 16'd5, 16'd1};
	int   phase_items [NUM_PHASES] = '{250, 200, 200, 60, 200, 250, 200, 300};

	tick_rate_window_averager uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .func(func), .timestamp_us(timestamp_us),
		.out_valid(out_valid), .out_ready(out_ready),
		.avg_short(avg_short), .avg_minute(avg_minute),
		.avg_half_hour(avg_half_hour), .avg_hour(avg_hour)
	);

	tra_window_checker window_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .func(func), .timestamp_us(timestamp_us),
		.out_valid(out_valid), .out_ready(out_ready),
		.avg_short(avg_short), .avg_minute(avg_minute),
		.avg_half_hour(avg_half_hour), .avg_hour(avg_hour),
		.mismatches(failures), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// A write or read of the update period register, entered and left at a falling edge.
	task automatic apb_access(input logic write, input logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= TPU_ADDR;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one item and hold it until the transfer, then maybe leave a gap.
	task automatic offer(input logic f, input logic [TS_W-1:0] stamp);
		in_valid <= 1'b1;
		func <= f;
		timestamp_us <= stamp;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
	endtask

	// Drain all results and let a pending sample update finish before the register changes.
	task automatic retune(input tpu_t value);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		apb_access(1'b1, PDATA_W'(value));
		apb_access(1'b0, '0);
	endtask

	function automatic logic [TS_W-1:0] next_delta();
		case ($urandom_range(0, 9))
			0:          return '0;
			1, 2:       return $urandom_range(1, 1500);
			8:          return $urandom_range(300_000, 50_000_000);
			9:          return $urandom();
			default:    return $urandom_range(1500, 300_000);
		endcase
	endfunction

	task automatic random_item();
		if ($urandom_range(0, 4) == 0) begin
			offer(FUNC_QUERY, $urandom());
		end else begin
			clock_us += next_delta();
			offer(FUNC_TICK, clock_us);
		end
	endtask

	// Receiver: random stall bursts, one long hold-off on request, none once calm.
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_output) begin
				hold_output = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		func = FUNC_TICK;
		timestamp_us = '0;
		clock_us = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed part: reset value, empty windows, first tick, saturation, wrap.
		apb_access(1'b0, '0);
		offer(FUNC_QUERY, 32'hFFFF_FFFF);
		clock_us = 32'hFFFF_FF00;
		offer(FUNC_TICK, clock_us);
		retune(16'd1);
		offer(FUNC_TICK, clock_us);
		clock_us += 32'd5;
		offer(FUNC_TICK, clock_us);
		clock_us += 32'd1_000_000;
		offer(FUNC_TICK, clock_us);
		clock_us += 32'hFFFF_FFFF;
		offer(FUNC_TICK, clock_us);
		offer(FUNC_QUERY, '0);
		// Enough samples to wrap the short ring.
		repeat (7) begin
			clock_us += $urandom_range(2000, 400_000);
			offer(FUNC_TICK, clock_us);
		end
		offer(FUNC_QUERY, 32'h5555_AAAA);
		retune(16'd0);
		clock_us += 32'd40_000;
		offer(FUNC_TICK, clock_us);
		offer(FUNC_QUERY, 32'hAAAA_5555);
		// Lowering the period below the running count takes a sample on the next tick.
		retune(16'hFFFF);
		repeat (3) begin
			clock_us += 32'd25_000;
			offer(FUNC_TICK, clock_us);
		end
		retune(16'd2);
		clock_us += 32'd25_000;
		offer(FUNC_TICK, clock_us);
		offer(FUNC_QUERY, '0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			retune(phase_tpu[p]);
			if (p == NUM_PHASES - 1)
				calm = 1'b1;
			for (int k = 0; k < phase_items[p]; k++) begin
				if (p == 1 && k == 40)
					hold_output = 1'b1;
				random_item();
			end
		end

		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
